// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic       OP_PUSH   = 1'b0;
  localparam logic       OP_POP    = 1'b1;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] entry_value;
    logic signed [31:0] entry_priority;
  } in_word_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] out_value;
    logic signed [31:0] out_priority;
    logic        [4:0]  fill_level;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_cmd_t;

endpackage

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue of CAPACITY entries built as a chain of slot cells.
// The result word for an accepted word is in the output register in the next cycle.
// Throughput: one push or pop per cycle while in_stall is low; every cell compares and shifts at once.
// Reset (rst_n, synchronous, low) clears the fill count and output valid;
// slot contents are undefined until written.
module sorted_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_word_t out_word
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_word_t        out_word_r, out_word_nxt;

  logic      accept;
  logic      full, empty;
  cell_cmd_t cmd;
  entry_t    new_ent;
  entry_t    ents  [CAPACITY];
  logic      keeps [CAPACITY];

  // output register frees up as soon as the current word is taken
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  assign new_ent.value = in_word.entry_value;
  assign new_ent.prio  = in_word.entry_priority;

  // dropped pushes and empty pops leave the chain alone
  assign cmd.push = accept && (in_word.operation == OP_PUSH) && !full;
  assign cmd.pop  = accept && (in_word.operation == OP_POP) && !empty;

  // Cells: head at index 0. Occupancy comes from the fill count, so the
  // insert point is the first cell that is empty or holds a lower priority.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    entry_t left_ent, right_ent;
    logic   left_keep;

    assign occ = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_ent  = new_ent;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_ent  = ents[i-1];
      assign left_keep = keeps[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = ents[i];   // vacated slot, contents don't matter
    end else begin : g_body
      assign right_ent = ents[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .left_keep (left_keep),
      .right_ent (right_ent),
      .ent       (ents[i]),
      .keep      (keeps[i])
    );
  end

  always_comb begin
    count_nxt    = count_r;
    out_word_nxt = out_word_r;
    if (accept) begin
      out_word_nxt.status       = ST_OK;
      out_word_nxt.out_value    = '0;
      out_word_nxt.out_priority = '0;
      if (in_word.operation == OP_PUSH) begin
        if (full) begin
          out_word_nxt.status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          out_word_nxt.status = ST_EMPTY;
        end else begin
          out_word_nxt.out_value    = ents[0].value;
          out_word_nxt.out_priority = ents[0].prio;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      out_word_nxt.fill_level = 5'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    out_word_r <= out_word_nxt;
  end

endmodule

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts toward tail on push
// and toward head on pop. Depends on spq_pkg.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               occ,
  input  spq_pkg::entry_t    new_ent,
  input  spq_pkg::entry_t    left_ent,
  input  logic               left_keep,
  input  spq_pkg::entry_t    right_ent,
  output spq_pkg::entry_t    ent,
  output logic               keep
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // stays put on push: occupied and not lower than the incoming priority
  assign keep = occ && !(ent_r.prio < new_ent.prio);
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.push) begin
      if (!keep) begin
        ent_nxt = left_keep ? new_ent : left_ent;
      end
    end else if (cmd.pop) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== tb/sorted_priority_queue_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sorted_priority_queue: directed and random push/pop words.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module sorted_priority_queue_tb;
  import spq_pkg::*;

  // Quiet cycles (no word accepted on either side) before the run is declared hung.
  localparam int QUIET_LIMIT    = 2000;
  // Random words per idling phase; three phases give about 700 words.
  localparam int RAND_PER_PHASE = 234;
  // Cycles to watch for stray results once nothing is expected (output register + margin).
  localparam int DRAIN_CYCLES   = 4;

  // Shadow queue: predicts the reply word for each accepted word and keeps the
  // replies that are still due, oldest first.
  class pq_tracker;
    int        held_value[$];
    int        held_prio[$];
    out_word_t replies_due[$];
    int        errors;

    function void note_word(in_word_t w);
      out_word_t r;
      int        pos;
      r = '0;
      if (w.operation == OP_PUSH) begin
        if (held_prio.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < held_prio.size() && held_prio[pos] >= int'(w.entry_priority)) pos++;
          held_value.insert(pos, int'(w.entry_value));
          held_prio.insert(pos, int'(w.entry_priority));
          r.status = ST_OK;
        end
      end else begin
        if (held_prio.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status       = ST_OK;
          r.out_value    = held_value.pop_front();
          r.out_priority = held_prio.pop_front();
        end
      end
      r.fill_level = 5'(held_prio.size());
      replies_due.push_back(r);
    endfunction

    function void check_reply(out_word_t got);
      out_word_t exp_w;
      if (replies_due.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_w = replies_due.pop_front();
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, got %0d", exp_w.status, got.status);
        errors++;
      end
      if (got.out_value !== exp_w.out_value) begin
        $error("out_value: expected %0d, got %0d", exp_w.out_value, got.out_value);
        errors++;
      end
      if (got.out_priority !== exp_w.out_priority) begin
        $error("out_priority: expected %0d, got %0d", exp_w.out_priority, got.out_priority);
        errors++;
      end
      if (got.fill_level !== exp_w.fill_level) begin
        $error("fill_level: expected %0d, got %0d", exp_w.fill_level, got.fill_level);
        errors++;
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // per-cycle idle odds in percent, set per phase by the main sequence
  int in_idle_pct  = 0;
  int out_idle_pct = 0;

  pq_tracker sb = new();

  sorted_priority_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Offer one word, with random idle cycles ahead of it, and hold it until the
  // DUT takes it. in_valid is left high so back-to-back words get one NBA per step.
  task automatic send_word(input logic op, input int val, input int prio);
    in_word_t w;
    w.operation      = op;
    w.entry_value    = val;
    w.entry_priority = prio;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  // Mostly a narrow band so ties (FIFO order among equals) are common; the rest
  // spans the full signed range and its edges.
  function automatic int pick_prio();
    int p;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: p = int'($urandom_range(6)) - 3;
      6, 7:             p = $urandom();
      8: begin
        case ($urandom_range(3))
          0:       p = 32'h7FFF_FFFF;
          1:       p = 32'h8000_0000;
          2:       p = 0;
          default: p = -1;
        endcase
      end
      default: p = ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000) ^ $urandom_range(3);
    endcase
    return p;
  endfunction

  // Result side: sample the handshake as seen at the edge, then pick the next stall.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_reply(out_word);
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // Hang detector: any accepted word on either side restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main_seq
    // Directed pushes: extremes of value and priority, ties at zero and at
    // both priority extremes, 16 entries in all so the queue ends up full.
    int dir_val[16]  = '{1, 2, 32'h7FFF_FFFF, 32'h8000_0000, 0, -1, 3, 4,
                         5, 6, 7, 8, 9, 10, 11, 12};
    int dir_prio[16] = '{0, 0, 32'h7FFF_FFFF, 32'h8000_0000, -1, 1, 0, 32'h7FFF_FFFF,
                         32'h8000_0000, 5, -5, 100, -100, 2, -2, 0};
    int   push_bias;
    logic op;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 21;
    out_idle_pct = 64;

    // pop on empty queue
    send_word(OP_POP, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    for (int i = 0; i < 16; i++) send_word(OP_PUSH, dir_val[i], dir_prio[i]);
    // push on full queue is dropped even with the top priority
    send_word(OP_PUSH, 32'h1234_5678, 32'h7FFF_FFFF);
    // head comes out: max-priority entries in arrival order, then the rest
    for (int i = 0; i < 6; i++) send_word(OP_POP, $urandom(), $urandom());

    // Three idling phases; the push bias changes every 32 words so the queue
    // swings between empty and full many times.
    push_bias = 50;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_idle_pct  = 21;
          out_idle_pct = 64;
        end
        1: begin
          in_idle_pct  = 64;
          out_idle_pct = 21;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (n % 32 == 0) begin
          case ($urandom_range(2))
            0:       push_bias = 15;
            1:       push_bias = 50;
            default: push_bias = 85;
          endcase
        end
        op = ($urandom_range(99) < push_bias) ? OP_PUSH : OP_POP;
        send_word(op, $urandom(), pick_prio());
      end
    end

    in_valid <= 1'b0;
    // watchdog bounds this wait if replies go missing
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
